>>> rtl/core/lrp_pkg.sv
// shared constants for the lcg range picker
package lrp_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 5;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [WORD_W:0]   t_wide;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_word LCG_MUL     = 32'd1664525;
    localparam t_word LCG_INC     = 32'd1013904223;
    localparam t_word SMALL_LIMIT = 32'd1024;
    localparam int unsigned SMALL_SHIFT = 10;

    localparam t_cnt CNT_LAST = t_cnt'(WORD_W - 1);

endpackage

>>> rtl/core/lcg_range_picker.sv
// lcg range picker: draws a pseudo-random value from an inclusive range
//
// each request carries a lower and an upper bound. the current 32-bit
// generator word is the raw draw; the word then advances as
// word*1664525+1013904223 mod 2^32. with an upper bound below 1024 the draw
// is shifted right by 10 first. the draw is reduced modulo the span
// (upper-lower+1) and the lower bound is added; hit_lowest flags a result
// equal to the lower bound. an inverted range gives bad_range=1,
// picked_value=0, hit_lowest=1 and still advances the generator. the full
// range (span of 2^32) passes the draw through unreduced.
// a write to the seed port loads the generator word directly; write it only
// while no request is in flight. a request is accepted in idle and passes
// the setup state, the run state (a bit-serial remainder and a bit-serial
// generator multiply running side by side) and the result state; a new
// request is taken only after the result state has loaded the output register.
// the result sits in an output register, so the next request is taken while
// an earlier result still waits downstream; if that result is still stalled
// when the next one is ready, the result cycle repeats until it drains.
module lcg_range_picker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_seed_we,
    input  logic [31:0] i_seed,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_lower_bound,
    input  logic [31:0] i_upper_bound,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_picked_value,
    output logic        o_hit_lowest,
    output logic        o_bad_range
);

    // sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETUP  = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]         r_state;
    lrp_pkg::t_cnt      r_cnt;

    // generator word, the architectural state
    lrp_pkg::t_word     r_gen;

    // captured request
    lrp_pkg::t_word     r_lo;
    lrp_pkg::t_word     r_hi;
    lrp_pkg::t_word     r_draw;
    logic               r_bad;

    // remainder datapath: dividend shifts out msb first
    lrp_pkg::t_word     r_dvd;
    lrp_pkg::t_word     r_rem;
    lrp_pkg::t_wide     r_dvs;

    // multiply datapath: multiplier shifts out lsb first
    lrp_pkg::t_word     r_mplr;
    lrp_pkg::t_word     r_mcand;
    lrp_pkg::t_word     r_acc;

    // output register
    logic               r_out_valid;
    lrp_pkg::t_word     r_out_value;
    logic               r_out_hit;
    logic               r_out_bad;

    logic               w_in_acc;
    logic               w_out_take;
    logic               w_run_last;
    logic               w_load_out;
    lrp_pkg::t_wide     n_trial;
    lrp_pkg::t_wide     n_diff;
    lrp_pkg::t_word     n_rem;
    lrp_pkg::t_word     n_acc;
    lrp_pkg::t_word     n_pick;
    logic               n_small;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_take  = r_out_valid && !i_out_stall;
    assign w_run_last  = (r_state == ST_RUN) && (r_cnt == lrp_pkg::CNT_LAST);
    // result register is free when empty or being drained this cycle
    assign w_load_out  = (r_state == ST_FINISH) && (!r_out_valid || !i_out_stall);

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        n_trial = {r_rem, r_dvd[lrp_pkg::WORD_W-1]};
        n_diff  = n_trial - r_dvs;
        if (n_trial >= r_dvs) begin
            n_rem = n_diff[lrp_pkg::WORD_W-1:0];
        end else begin
            n_rem = n_trial[lrp_pkg::WORD_W-1:0];
        end
    end

    // one shift-add step of word*mul, truncated to the word
    always_comb begin
        if (r_mplr[0]) begin
            n_acc = r_acc + r_mcand;
        end else begin
            n_acc = r_acc;
        end
    end

    assign n_small = (r_hi < lrp_pkg::SMALL_LIMIT);

    // remainder zero means the pick lands on the lower bound, even mod 2^32
    assign n_pick = r_rem + r_lo;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_state <= ST_RUN;
                    r_cnt   <= '0;
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_run_last) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // generator: seed write loads it, last multiply step advances it
            if (i_seed_we) begin
                r_gen <= i_seed;
            end else if (w_run_last) begin
                r_gen <= n_acc;
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_lo   <= i_lower_bound;
            r_hi   <= i_upper_bound;
            r_draw <= r_gen;
        end

        if (r_state == ST_SETUP) begin
            r_bad   <= (r_lo > r_hi);
            // 33-bit span: full range becomes 2^32 and leaves the draw as is
            r_dvs   <= {1'b0, r_hi} - {1'b0, r_lo} + 1'b1;
            r_dvd   <= n_small ? (r_draw >> lrp_pkg::SMALL_SHIFT) : r_draw;
            r_rem   <= '0;
            r_mplr  <= r_draw;
            r_mcand <= lrp_pkg::LCG_MUL;
            r_acc   <= lrp_pkg::LCG_INC;
        end

        if (r_state == ST_RUN) begin
            r_dvd   <= r_dvd << 1;
            r_rem   <= n_rem;
            r_mplr  <= r_mplr >> 1;
            r_mcand <= r_mcand << 1;
            r_acc   <= n_acc;
        end

        if (w_load_out) begin
            r_out_bad <= r_bad;
            if (r_bad) begin
                r_out_value <= '0;
                r_out_hit   <= 1'b1;
            end else begin
                r_out_value <= n_pick;
                r_out_hit   <= (r_rem == '0);
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_picked_value = r_out_value;
    assign o_hit_lowest   = r_out_hit;
    assign o_bad_range    = r_out_bad;

    // inverted range always reports value 0 with the hit flag
    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_range) |-> (o_picked_value == '0 && o_hit_lowest))
        else $error("bad range result malformed");

    // an accepted request starts the setup cycle and blocks further requests
    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_SETUP && o_in_stall))
        else $error("request accept did not start setup");

    // generator word moves only on a seed write or the end of a multiply
    a_gen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_seed_we && !w_run_last) |=> $stable(r_gen))
        else $error("generator word changed unexpectedly");

    // the serial loop runs its full length before the result cycle
    a_run_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_run_last |=> (r_state == ST_FINISH))
        else $error("serial loop did not end in result cycle");

endmodule

>>> tb/sv/tb_lcg_range_picker.sv
// self-checking testbench for the lcg range picker
module tb_lcg_range_picker;

    // what the stimulus plan holds: a request, a seed write, or a wait for quiet
    typedef enum logic [1:0] {
        ACT_REQUEST,
        ACT_SEED,
        ACT_DRAIN
    } t_action;

    typedef struct {
        t_action        act;
        lrp_pkg::t_word lo;
        lrp_pkg::t_word hi;
        lrp_pkg::t_word seed;
    } t_planned;

    // one predicted result
    typedef struct {
        lrp_pkg::t_word pick;
        logic           hit;
        logic           bad;
    } t_pick;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;

    // block inputs, all known from time zero
    logic           seed_we   = 1'b0;
    lrp_pkg::t_word seed_val  = '0;
    logic           in_valid  = 1'b0;
    lrp_pkg::t_word lower     = '0;
    lrp_pkg::t_word upper     = '0;
    logic           out_stall = 1'b0;

    logic           in_stall;
    logic           out_valid;
    lrp_pkg::t_word picked_value;
    logic           hit_lowest;
    logic           bad_range;

    lcg_range_picker uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (seed_we),
        .i_seed         (seed_val),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_lower_bound  (lower),
        .i_upper_bound  (upper),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_picked_value (picked_value),
        .o_hit_lowest   (hit_lowest),
        .o_bad_range    (bad_range)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // stimulus plan, filled before reset is released
    t_planned       plan[$];
    // predicted results in request order
    t_pick          expected_picks[$];
    // our copy of the generator word, follows seed writes and requests
    lrp_pkg::t_word generator_word = '0;
    // results still owed, published by the checker for the sender
    int unsigned    outstanding = 0;
    int unsigned    error_count = 0;

    // sender and receiver pacing
    int unsigned send_gap    = 0;
    int unsigned send_quiet  = 0;
    int unsigned stall_left  = 0;
    int unsigned recv_quiet  = 0;

    task automatic report_mismatch(input string what, input lrp_pkg::t_word got,
                                   input lrp_pkg::t_word want);
        error_count++;
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    endtask

    // wait length for one item; now and then a stretch with no waiting at all
    function automatic int unsigned draw_wait(inout int unsigned quiet_left);
        if (quiet_left != 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            quiet_left = $urandom_range(15, 50);
        end
        return $urandom_range(0, 12);
    endfunction

    // expected result of one request; advances the generator word
    function automatic t_pick draw_from_range(input lrp_pkg::t_word lo,
                                              input lrp_pkg::t_word hi);
        lrp_pkg::t_word raw;
        lrp_pkg::t_word span;
        t_pick          res;
        raw = generator_word;
        generator_word = generator_word * lrp_pkg::LCG_MUL + lrp_pkg::LCG_INC;
        // inverted range: fixed result, generator already moved on
        if (lo > hi) begin
            res.pick = '0;
            res.hit  = 1'b1;
            res.bad  = 1'b1;
            return res;
        end
        // small upper bound uses the high bits of the draw
        if (hi < lrp_pkg::SMALL_LIMIT) begin
            raw = raw >> lrp_pkg::SMALL_SHIFT;
        end
        // full range wraps the span to zero and skips the reduction
        span = hi - lo + 32'd1;
        if (span != '0) begin
            raw = raw % span;
        end
        res.pick = raw + lo;
        res.hit  = (res.pick == lo);
        res.bad  = 1'b0;
        return res;
    endfunction

    task automatic plan_request(input lrp_pkg::t_word lo, input lrp_pkg::t_word hi);
        t_planned p;
        p.act  = ACT_REQUEST;
        p.lo   = lo;
        p.hi   = hi;
        p.seed = '0;
        plan.push_back(p);
    endtask

    task automatic plan_seed(input lrp_pkg::t_word value);
        t_planned p;
        p.act  = ACT_SEED;
        p.lo   = '0;
        p.hi   = '0;
        p.seed = value;
        plan.push_back(p);
    endtask

    task automatic plan_drain();
        t_planned p;
        p.act  = ACT_DRAIN;
        p.lo   = '0;
        p.hi   = '0;
        p.seed = '0;
        plan.push_back(p);
    endtask

    // sender: walks the plan, holds a request until taken, pauses between items
    always @(posedge i_clk) begin
        logic taken;
        logic next_valid;
        logic next_we;
        if (i_rst_n) begin
            taken      = in_valid && !in_stall;
            next_valid = in_valid && !taken;
            next_we    = 1'b0;
            if (!next_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (plan.size() != 0) begin
                    case (plan[0].act)
                        ACT_REQUEST: begin
                            lower      <= plan[0].lo;
                            upper      <= plan[0].hi;
                            next_valid = 1'b1;
                            send_gap   = draw_wait(send_quiet);
                            void'(plan.pop_front());
                        end
                        ACT_SEED: begin
                            // only with nothing in flight and the last write done
                            if (!taken && outstanding == 0 && !seed_we) begin
                                seed_val <= plan[0].seed;
                                next_we  = 1'b1;
                                void'(plan.pop_front());
                            end
                        end
                        ACT_DRAIN: begin
                            // hold off until every owed result is back
                            if (!taken && outstanding == 0) begin
                                void'(plan.pop_front());
                            end
                        end
                        default: begin
                            void'(plan.pop_front());
                        end
                    endcase
                end
            end
            in_valid <= next_valid;
            seed_we  <= next_we;
        end
    end

    // receiver and checker: results are checked before new requests are
    // predicted, all in one block so queue order never depends on scheduling
    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_picks.size() == 0) begin
                    report_mismatch("unrequested result", picked_value, '0);
                end else begin
                    want = expected_picks.pop_front();
                    if (picked_value !== want.pick) begin
                        report_mismatch("picked_value", picked_value, want.pick);
                    end
                    if (hit_lowest !== want.hit) begin
                        report_mismatch("hit_lowest", lrp_pkg::t_word'(hit_lowest),
                                        lrp_pkg::t_word'(want.hit));
                    end
                    if (bad_range !== want.bad) begin
                        report_mismatch("bad_range", lrp_pkg::t_word'(bad_range),
                                        lrp_pkg::t_word'(want.bad));
                    end
                end
                // stall cycles the next result will sit through
                stall_left = draw_wait(recv_quiet);
            end else if (out_valid && stall_left != 0) begin
                stall_left--;
            end
            if (in_valid && !in_stall) begin
                expected_picks.push_back(draw_from_range(lower, upper));
            end
            // the block reloads its generator on the same edge
            if (seed_we) begin
                generator_word = seed_val;
            end
            out_stall   <= (stall_left != 0);
            outstanding <= expected_picks.size();
        end
    end

    // stimulus plan, reset, and the end of the run
    initial begin
        lrp_pkg::t_word a;
        lrp_pkg::t_word b;
        lrp_pkg::t_word lo;
        lrp_pkg::t_word hi;
        int             phase;
        int             n;

        // directed: extremes, inverted, full range, small upper bound
        plan_request(32'h0000_0000, 32'h0000_0000);
        plan_request(32'h0000_0000, 32'hFFFF_FFFF);
        plan_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        plan_request(32'hFFFF_FFFF, 32'h0000_0000);
        plan_request(32'h0000_0001, 32'h0000_0000);
        plan_request(32'h0000_0000, 32'h0000_03FF);
        plan_request(32'h0000_0000, 32'h0000_0400);
        plan_request(32'h0000_03FF, 32'h0000_03FF);
        plan_request(32'h0000_0200, 32'h0000_03FF);
        plan_request(32'h0000_0400, 32'h0000_03FF);
        plan_request(32'h0000_0000, 32'h7FFF_FFFF);
        plan_request(32'h8000_0000, 32'hFFFF_FFFF);
        plan_request(32'h0000_0001, 32'hFFFF_FFFF);
        plan_request(32'h0000_0000, 32'hFFFF_FFFE);
        plan_request(32'h0000_0064, 32'h0000_00C8);
        plan_request(32'h1234_5678, 32'h1234_5679);
        plan_request(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        plan_seed(32'hFFFF_FFFF);
        plan_request(32'h0000_0000, 32'hFFFF_FFFF);
        plan_request(32'h0000_0000, 32'h0000_03FF);
        plan_request(32'h0000_0005, 32'h0000_0009);

        // random phases, each under its own seed
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: plan_seed(32'h0000_0000);
                1: plan_seed(32'hFFFF_FFFF);
                2: plan_seed(32'h8000_0000);
                default: plan_seed($urandom);
            endcase
            for (n = 0; n < 200; n++) begin
                if ((phase == 2 && n == 100) || $urandom_range(0, 149) == 0) begin
                    plan_drain();
                end
                case ($urandom_range(0, 9))
                    0, 1: begin
                        // small upper bound, now and then inverted
                        hi = $urandom_range(0, 1023);
                        lo = ($urandom_range(0, 7) == 0)
                             ? lrp_pkg::t_word'($urandom)
                             : lrp_pkg::t_word'($urandom_range(0, hi));
                    end
                    2, 3: begin
                        // narrow span anywhere, may wrap into an inverted range
                        lo = $urandom;
                        hi = lo + $urandom_range(0, 15);
                    end
                    4, 5: begin
                        lo = $urandom;
                        hi = lo + lrp_pkg::t_word'($urandom);
                    end
                    6: begin
                        lo = $urandom;
                        hi = $urandom;
                    end
                    7: begin
                        // zero-based spans of every magnitude
                        lo = '0;
                        hi = lrp_pkg::t_word'($urandom) >> $urandom_range(0, 31);
                    end
                    8: begin
                        // full range and its near neighbors
                        lo = $urandom_range(0, 1);
                        hi = 32'hFFFF_FFFF - $urandom_range(0, 1);
                    end
                    default: begin
                        // inverted range
                        a  = $urandom;
                        b  = $urandom;
                        lo = (a > b) ? a : b;
                        hi = (a > b) ? b : a;
                    end
                endcase
                plan_request(lo, hi);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent, every result back, no write pending; sampled
        // between rising edges so all updates of an edge have settled
        do begin
            @(negedge i_clk);
        end while (plan.size() != 0 || in_valid || seed_we || outstanding != 0);
        // room for a stray result after the last one
        repeat (40) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial begin
        #(12 * 400_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> lcg_range_picker.f
rtl/core/lrp_pkg.sv
rtl/core/lcg_range_picker.sv
tb/sv/tb_lcg_range_picker.sv
